// File: rtl/sat_pkg.sv
// ============================================================================
// sat_pkg: shared types and constants of the sorted array table
// Command kinds, status codes, field widths and the sequencer state type.
// ============================================================================
package sat_pkg;

    localparam int Capacity = 64;
    localparam int AddrW    = $clog2(Capacity);
    localparam int FillW    = $clog2(Capacity + 1);
    localparam int ValW     = 32;
    localparam int SumW     = ValW + FillW - 1;

    typedef enum logic [2:0] {
        K_INSERT = 3'd0,
        K_REMOVE = 3'd1,
        K_READ   = 3'd2,
        K_BSEARCH = 3'd3,
        K_LIST   = 3'd4,
        K_AVG    = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_SH,
        S_REM_RD,
        S_REM_SH,
        S_READ,
        S_BS_RD,
        S_BS_CHK,
        S_LS_RD,
        S_LS_CHK,
        S_DIV,
        S_OUT
    } t_state;

    // One result word as it goes to the output register.
    typedef struct packed {
        logic         last;
        logic [FillW-1:0] fill;
        logic [AddrW-1:0] found_at;
        logic [ValW-1:0]  data;
        t_status          status;
    } t_result;

    // Handshake between the sequencer and the divider.
    typedef struct packed {
        logic             start;
        logic [SumW-1:0]  dividend;
        logic [FillW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [ValW-1:0] quotient;
    } t_div_rsp;

endpackage

// File: rtl/sat_divider.sv
// ============================================================================
// sat_divider: serial signed divide for the table average
// Restoring divide of the running sum by the entry count, one quotient bit a
// cycle, with the quotient truncated toward zero.
// ============================================================================
module sat_divider
    import sat_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CntW = $clog2(SumW + 1);

    logic [SumW-1:0]  r_quo;
    logic [SumW-1:0]  r_rem;
    logic [FillW-1:0] r_den;
    logic             r_neg;
    logic [CntW-1:0]  r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [SumW:0]    n_rem;
    logic [SumW:0]    n_diff;
    logic [SumW-1:0]  n_abs;
    logic [SumW-1:0]  n_qs;

    // One trial subtraction per cycle.
    always_comb begin
        n_abs  = i_req.dividend[SumW-1] ? (~i_req.dividend + 1'b1) : i_req.dividend;
        n_rem  = {r_rem, r_quo[SumW-1]};
        n_diff = n_rem - {{(SumW + 1 - FillW){1'b0}}, r_den};
        n_qs   = r_neg ? (~r_quo + 1'b1) : r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(SumW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= n_abs;
            r_rem <= '0;
            r_den <= i_req.divisor;
            r_neg <= i_req.dividend[SumW-1];
        end else if (r_busy) begin
            if (!n_diff[SumW]) begin
                r_rem <= n_diff[SumW-1:0];
                r_quo <= {r_quo[SumW-2:0], 1'b1};
            end else begin
                r_rem <= n_rem[SumW-1:0];
                r_quo <= {r_quo[SumW-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = n_qs[ValW-1:0];

endmodule

// File: rtl/sorted_array_table.sv
// ============================================================================
// sorted_array_table: ascending table of signed 32-bit values
// Command-driven sorted table held in one synchronous memory.
// ============================================================================
// Usage: commands arrive on the s_axis channel (one word each); results leave
// on m_axis. tuser carries the command kind on input and the status on output;
// tlast marks the final result of a command. Only a list command gives more
// than one result word.
// Memory reads are registered: data returns in the cycle after the address.
// Insert and remove shift entries one at a time, each with a read and a
// write; average runs in the serial divider. A list match word leaves once
// the next match or the end of the table is seen, so its tlast is known
// when it is sent. One command is processed at a time; s_axis_tready is
// high only when the sequencer is idle and the output register is empty or
// being emptied.
// Reset clears the entry count and running sum; the table memory holds no
// reset value, and entries beyond the count are never used.
// A stalled receiver holds the result in the output register; the sequencer
// waits there until the word is taken.
// ============================================================================
module sorted_array_table
    import sat_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: [31:0] value, [37:32] position, [39:38] zero
    input  logic [39:0] s_axis_tdata,
    // tuser: [2:0] kind
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: [31:0] data, [37:32] found_at, [44:38] fill, [47:45] zero
    output logic [47:0] m_axis_tdata,
    // tuser: [1:0] status
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    // Table memory.
    logic [ValW-1:0]  r_mem [Capacity];
    logic [ValW-1:0]  r_rdata;
    logic             n_we;
    logic [AddrW-1:0] n_waddr;
    logic [ValW-1:0]  n_wdata;
    logic [AddrW-1:0] n_raddr;

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_waddr] <= n_wdata;
        end
        r_rdata <= r_mem[n_raddr];
    end

    // Sequencer state.
    t_state              r_state, n_state;
    logic [FillW-1:0]    r_count, n_count;
    logic [SumW-1:0]     r_sum, n_sum;
    logic [ValW-1:0]     r_val, n_val;
    logic [FillW-1:0]    r_idx, n_idx;
    logic [FillW:0]      r_lo, n_lo;
    logic [FillW:0]      r_hi, n_hi;
    logic                r_hit, n_hit;
    logic                r_ovalid, n_ovalid;
    t_result             r_res, n_res;
    t_div_req            n_div;
    t_div_rsp            w_div;

    logic                w_out_free;
    logic [FillW:0]      w_mid;
    logic signed [ValW-1:0] w_rd_s;
    logic signed [ValW-1:0] w_val_s;

    sat_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div),
        .o_rsp   (w_div)
    );

    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_mid      = (r_lo + r_hi) >> 1;
    assign w_rd_s     = r_rdata;
    assign w_val_s    = r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_idx  <= n_idx;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_hit  <= n_hit;
        r_res  <= n_res;
    end

    // Next state, memory control and result building.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_sum    = r_sum;
        n_val    = r_val;
        n_idx    = r_idx;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_hit    = r_hit;
        n_res    = r_res;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_we     = 1'b0;
        n_waddr  = r_idx[AddrW-1:0];
        n_wdata  = r_val;
        n_raddr  = r_idx[AddrW-1:0];
        n_div    = '0;
        s_axis_tready = 1'b0;

        case (r_state)
            S_IDLE: begin
                s_axis_tready = w_out_free;
                if (s_axis_tvalid && w_out_free) begin
                    n_val  = s_axis_tdata[ValW-1:0];
                    n_res  = '0;
                    n_res.last = 1'b1;
                    n_res.fill = r_count;
                    n_state = S_OUT;
                    n_hit  = 1'b0;
                    case (s_axis_tuser)
                        K_INSERT: begin
                            if (r_count >= FillW'(Capacity)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                // Shift from the top down until the slot fits.
                                n_idx  = r_count;
                                n_state = S_INS_RD;
                            end
                        end
                        K_REMOVE, K_READ: begin
                            n_idx = {1'b0, s_axis_tdata[ValW +: AddrW]};
                            if ({1'b0, s_axis_tdata[ValW +: AddrW]} >= r_count) begin
                                n_res.status = ST_RANGE;
                            end else begin
                                n_raddr = s_axis_tdata[ValW +: AddrW];
                                n_state = (s_axis_tuser == K_READ) ? S_READ : S_REM_RD;
                            end
                        end
                        K_BSEARCH: begin
                            n_lo = '0;
                            n_hi = {1'b0, r_count} - 1'b1;
                            n_state = S_BS_RD;
                        end
                        K_LIST: begin
                            n_idx = '0;
                            n_state = S_LS_RD;
                        end
                        K_AVG: begin
                            if (r_count != '0) begin
                                n_div.start    = 1'b1;
                                n_div.dividend = r_sum;
                                n_div.divisor  = r_count;
                                n_state = S_DIV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Insert: read entry idx-1, move it up if larger than the value.
            S_INS_RD: begin
                if (r_idx == '0) begin
                    n_we    = 1'b1;
                    n_waddr = '0;
                    n_wdata = r_val;
                    n_count = r_count + 1'b1;
                    n_sum   = r_sum + SumW'(w_val_s);
                    n_res.fill = r_count + 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_raddr = AddrW'(r_idx - 1'b1);
                    n_state = S_INS_SH;
                end
            end
            S_INS_SH: begin
                n_we = 1'b1;
                if (w_val_s < w_rd_s) begin
                    n_waddr = r_idx[AddrW-1:0];
                    n_wdata = r_rdata;
                    n_idx   = r_idx - 1'b1;
                    n_state = S_INS_RD;
                end else begin
                    n_waddr = r_idx[AddrW-1:0];
                    n_wdata = r_val;
                    n_count = r_count + 1'b1;
                    n_sum   = r_sum + SumW'(w_val_s);
                    n_res.fill = r_count + 1'b1;
                    n_state = S_OUT;
                end
            end

            // Remove: first read gives the removed value, then pull down.
            S_REM_RD: begin
                if (!r_hit) begin
                    n_sum = r_sum - SumW'(w_rd_s);
                    n_hit = 1'b1;
                end else begin
                    n_we    = 1'b1;
                    n_waddr = AddrW'(r_idx - 1'b1);
                    n_wdata = r_rdata;
                end
                if (r_idx + 1'b1 >= r_count) begin
                    n_count = r_count - 1'b1;
                    n_res.fill = r_count - 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_raddr = AddrW'(r_idx + 1'b1);
                    n_state = S_REM_SH;
                end
            end
            S_REM_SH: begin
                n_state = S_REM_RD;
            end

            S_READ: begin
                n_res.data = r_rdata;
                n_state = S_OUT;
            end

            // Binary search with floor midpoints.
            S_BS_RD: begin
                if ($signed(r_lo) > $signed(r_hi)) begin
                    n_res.status = ST_MISSING;
                    n_state = S_OUT;
                end else begin
                    n_raddr = w_mid[AddrW-1:0];
                    n_idx   = w_mid[FillW-1:0];
                    n_state = S_BS_CHK;
                end
            end
            S_BS_CHK: begin
                if (w_rd_s == w_val_s) begin
                    n_res.found_at = r_idx[AddrW-1:0];
                    n_state = S_OUT;
                end else if (w_rd_s > w_val_s) begin
                    n_hi = {1'b0, r_idx} - 1'b1;
                    n_state = S_BS_RD;
                end else begin
                    n_lo = {1'b0, r_idx} + 1'b1;
                    n_state = S_BS_RD;
                end
            end

            // Listing: S_LS_RD reads each entry once the output is free, S_LS_CHK
            // compares it. The latest match is held in r_lo and sent when the next
            // match or the end of the table shows whether it is the final word.
            S_LS_RD: begin
                if (!r_ovalid || m_axis_tready) begin
                    if (r_idx >= r_count) begin
                        if (r_hit) begin
                            n_res.status   = ST_OK;
                            n_res.found_at = r_lo[AddrW-1:0];
                            n_res.last     = 1'b1;
                            n_res.fill     = r_count;
                        end else begin
                            n_res.status = ST_MISSING;
                            n_res.last   = 1'b1;
                        end
                        n_state = S_OUT;
                    end else begin
                        n_raddr = r_idx[AddrW-1:0];
                        n_state = S_LS_CHK;
                    end
                end
            end
            S_LS_CHK: begin
                if (w_rd_s == w_val_s) begin
                    if (r_hit) begin
                        n_ovalid = 1'b1;
                        n_res.status   = ST_OK;
                        n_res.found_at = r_lo[AddrW-1:0];
                        n_res.last     = 1'b0;
                        n_res.fill     = r_count;
                    end
                    n_hit = 1'b1;
                    n_lo  = {1'b0, r_idx};
                end
                n_idx   = r_idx + 1'b1;
                n_state = S_LS_RD;
            end

            S_DIV: begin
                if (w_div.done) begin
                    n_res.data = w_div.quotient;
                    n_state = S_OUT;
                end
            end

            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'b000, r_res.fill, r_res.found_at, r_res.data};
    assign m_axis_tuser  = r_res.status;
    assign m_axis_tlast  = r_res.last;

`ifndef NO_ASSERTIONS
    // The entry count never exceeds the capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FillW'(Capacity))
        else $error("entry count above capacity");

    // A stalled result holds its content.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> r_ovalid && $stable(r_res))
        else $error("result changed while stalled");

    // No command is taken while a divide is in flight.
    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> !s_axis_tready)
        else $error("command accepted during divide");
`endif

endmodule
